@@ rtl/eight_bit_alu_with_flags_defines.svh @@
// Assertion macros for the ALU block.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_DEFINES_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted (active low).
`define EBALU_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (prop)) \
    else $error("ALU assertion failed");
// Clocked assertion that also holds through reset.
`define EBALU_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("ALU assertion failed");
`else
`define EBALU_ASSERT(lbl, clk_s, rstn_s, prop)
`define EBALU_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

@@ rtl/ebalu_pkg.sv @@
`timescale 1ns / 1ps

package ebalu_pkg;

  localparam int unsigned KIND_W = 5;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BSEL_W = 3;

  // Operation codes; 20..31 are unused and pass through.
  typedef enum logic [KIND_W-1:0] {
    K_ADD = 5'd0,
    K_ADC = 5'd1,
    K_SUB = 5'd2,
    K_SBC = 5'd3,
    K_AND = 5'd4,
    K_OR  = 5'd5,
    K_XOR = 5'd6,
    K_CP  = 5'd7,
    K_INC = 5'd8,
    K_DEC = 5'd9,
    K_DAA = 5'd10,
    K_RLC = 5'd11,
    K_RRC = 5'd12,
    K_RL  = 5'd13,
    K_RR  = 5'd14,
    K_SLA = 5'd15,
    K_SRA = 5'd16,
    K_SLL = 5'd17,
    K_SRL = 5'd18,
    K_BIT = 5'd19
  } kind_t;

  // Flag byte bit positions.
  localparam int unsigned FB_S  = 7;
  localparam int unsigned FB_Z  = 6;
  localparam int unsigned FB_5  = 5;
  localparam int unsigned FB_H  = 4;
  localparam int unsigned FB_3  = 3;
  localparam int unsigned FB_PV = 2;
  localparam int unsigned FB_N  = 1;
  localparam int unsigned FB_C  = 0;

endpackage

@@ rtl/ebalu_if.sv @@
`timescale 1ns / 1ps

interface ebalu_in_if import ebalu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] acc_in;
  logic [BYTE_W-1:0] flags_in;
  logic [BYTE_W-1:0] operand;
  logic [BSEL_W-1:0] bit_select;
  logic [BYTE_W-1:0] xy_byte;

  modport source (output valid, kind, acc_in, flags_in, operand, bit_select, xy_byte,
                  input ready);
  modport sink   (input valid, kind, acc_in, flags_in, operand, bit_select, xy_byte,
                  output ready);
endinterface

interface ebalu_out_if import ebalu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] acc_out;
  logic [BYTE_W-1:0] flags_out;
  logic [BYTE_W-1:0] value_out;

  modport source (output valid, acc_out, flags_out, value_out, input ready);
  modport sink   (input valid, acc_out, flags_out, value_out, output ready);
endinterface

@@ rtl/eight_bit_alu_with_flags.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Payload                                              Transfer
// in_ch     in   kind, acc_in, flags_in, operand, bit_select, xy_byte  valid & ready
// out_ch    out  acc_out, flags_out, value_out                         valid & ready
//
// One item per cycle sustained while out_ch is not stalled. An item taken on in_ch
// is registered in the input stage, then moves into the result register, which
// raises out_ch.valid, once that register is empty or out_ch.ready is high.
// The flag logic between the two registers is a set of 8-bit add, subtract,
// increment, decrement and decimal-adjust paths and a few levels of selection.
// rst_n (synchronous, active low) empties both stages; payload is not reset.
// A stall on out_ch fills the input stage, then drops in_ch.ready.
`include "eight_bit_alu_with_flags_defines.svh"

module eight_bit_alu_with_flags
  import ebalu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ebalu_in_if.sink   in_ch,
  ebalu_out_if.source out_ch
);

  // S, Z and the two copy bits of a byte.
  function automatic logic [BYTE_W-1:0] szxy(input logic [BYTE_W-1:0] r);
    logic [BYTE_W-1:0] f;
    f        = '0;
    f[FB_S]  = r[7];
    f[FB_Z]  = (r == '0);
    f[FB_5]  = r[5];
    f[FB_3]  = r[3];
    return f;
  endfunction

  // ---------------------------------------------------------------------
  // Input stage
  // ---------------------------------------------------------------------
  logic              s1_valid_r, s1_valid_nxt;
  logic [KIND_W-1:0] s1_kind_r;
  logic [BYTE_W-1:0] s1_a_r, s1_f_r, s1_b_r, s1_xy_r;
  logic [BSEL_W-1:0] s1_bsel_r;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_acc_r, out_flags_r, out_val_r;
  logic [BYTE_W-1:0] acc_nxt, flags_nxt, val_nxt;

  logic in_xfer;    // input transfer this cycle
  logic s2_load;    // input stage moves into the result register

  assign s2_load     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s2_load;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= in_ch.kind;
      s1_a_r    <= in_ch.acc_in;
      s1_f_r    <= in_ch.flags_in;
      s1_b_r    <= in_ch.operand;
      s1_bsel_r <= in_ch.bit_select;
      s1_xy_r   <= in_ch.xy_byte;
    end
  end

  // ---------------------------------------------------------------------
  // ALU datapath
  // ---------------------------------------------------------------------
  logic              cin, hin, nin;
  logic              c_add, c_sub;
  logic [BYTE_W:0]   add9, sub9;
  logic [4:0]        add_h, sub_h;
  logic [BYTE_W-1:0] logic_r;
  logic              lo_gt9, hi_gt99, daa_c;
  logic [BYTE_W-1:0] corr, daa_r;
  logic              daa_h;
  logic [BYTE_W-1:0] sh_r;
  logic              sh_c;
  logic [BYTE_W-1:0] inc_r, dec_r;
  logic              bit_set;

  assign cin   = s1_f_r[FB_C];
  assign hin   = s1_f_r[FB_H];
  assign nin   = s1_f_r[FB_N];
  assign c_add = (s1_kind_r == K_ADC) && cin;
  assign c_sub = (s1_kind_r == K_SBC) && cin;

  // Ninth bit of the add is carry; of the subtract, borrow.
  assign add9  = {1'b0, s1_a_r} + {1'b0, s1_b_r} + {{BYTE_W{1'b0}}, c_add};
  assign add_h = {1'b0, s1_a_r[3:0]} + {1'b0, s1_b_r[3:0]} + {4'd0, c_add};
  assign sub9  = {1'b0, s1_a_r} - {1'b0, s1_b_r} - {{BYTE_W{1'b0}}, c_sub};
  assign sub_h = {1'b0, s1_a_r[3:0]} - {1'b0, s1_b_r[3:0]} - {4'd0, c_sub};

  assign inc_r = s1_b_r + 8'd1;
  assign dec_r = s1_b_r - 8'd1;

  // Decimal adjust
  assign lo_gt9  = (s1_a_r[3:0] > 4'd9);
  assign hi_gt99 = (s1_a_r > 8'h99);
  assign daa_c   = hi_gt99 || cin;
  assign corr    = {(daa_c ? 4'h6 : 4'h0), ((lo_gt9 || hin) ? 4'h6 : 4'h0)};
  assign daa_r   = nin ? (s1_a_r - corr) : (s1_a_r + corr);
  assign daa_h   = nin ? (hin && (s1_a_r[3:0] < 4'd6)) : lo_gt9;

  assign bit_set = s1_b_r[s1_bsel_r];

  always_comb begin
    case (s1_kind_r)
      K_AND:   logic_r = s1_a_r & s1_b_r;
      K_OR:    logic_r = s1_a_r | s1_b_r;
      default: logic_r = s1_a_r ^ s1_b_r;
    endcase
  end

  // Rotates and shifts: result byte and carry out.
  always_comb begin
    sh_c = s1_b_r[0];
    case (s1_kind_r)
      K_RLC:   begin sh_r = {s1_b_r[6:0], s1_b_r[7]}; sh_c = s1_b_r[7]; end
      K_RRC:   sh_r = {s1_b_r[0], s1_b_r[7:1]};
      K_RL:    begin sh_r = {s1_b_r[6:0], cin}; sh_c = s1_b_r[7]; end
      K_RR:    sh_r = {cin, s1_b_r[7:1]};
      K_SLA:   begin sh_r = {s1_b_r[6:0], 1'b0}; sh_c = s1_b_r[7]; end
      K_SRA:   sh_r = {s1_b_r[7], s1_b_r[7:1]};
      K_SLL:   begin sh_r = {s1_b_r[6:0], 1'b1}; sh_c = s1_b_r[7]; end
      default: sh_r = {1'b0, s1_b_r[7:1]};
    endcase
  end

  always_comb begin
    acc_nxt   = s1_a_r;
    flags_nxt = s1_f_r;
    val_nxt   = s1_a_r;
    case (s1_kind_r) inside
      K_ADD, K_ADC: begin
        acc_nxt          = add9[BYTE_W-1:0];
        flags_nxt        = szxy(add9[BYTE_W-1:0]);
        flags_nxt[FB_H]  = add_h[4];
        flags_nxt[FB_C]  = add9[BYTE_W];
        flags_nxt[FB_PV] = !(s1_a_r[7] ^ s1_b_r[7]) && (add9[7] ^ s1_a_r[7]);
        val_nxt          = add9[BYTE_W-1:0];
      end
      K_SUB, K_SBC, K_CP: begin
        flags_nxt        = szxy(sub9[BYTE_W-1:0]);
        flags_nxt[FB_N]  = 1'b1;
        flags_nxt[FB_H]  = sub_h[4];
        flags_nxt[FB_C]  = sub9[BYTE_W];
        flags_nxt[FB_PV] = (s1_a_r[7] ^ s1_b_r[7]) && (sub9[7] ^ s1_a_r[7]);
        if (s1_kind_r == K_CP) begin
          // compare copies bits 5 and 3 from the operand
          flags_nxt[FB_5] = s1_b_r[5];
          flags_nxt[FB_3] = s1_b_r[3];
        end else begin
          acc_nxt = sub9[BYTE_W-1:0];
          val_nxt = sub9[BYTE_W-1:0];
        end
      end
      K_AND, K_OR, K_XOR: begin
        acc_nxt          = logic_r;
        flags_nxt        = szxy(logic_r);
        flags_nxt[FB_PV] = ~^logic_r;
        flags_nxt[FB_H]  = (s1_kind_r == K_AND);
        val_nxt          = logic_r;
      end
      K_INC: begin
        flags_nxt        = szxy(inc_r);
        flags_nxt[FB_C]  = cin;
        flags_nxt[FB_H]  = (s1_b_r[3:0] == 4'hF);
        flags_nxt[FB_PV] = (s1_b_r == 8'h7F);
        val_nxt          = inc_r;
      end
      K_DEC: begin
        flags_nxt        = szxy(dec_r);
        flags_nxt[FB_N]  = 1'b1;
        flags_nxt[FB_C]  = cin;
        flags_nxt[FB_H]  = (s1_b_r[3:0] == 4'h0);
        flags_nxt[FB_PV] = (s1_b_r == 8'h80);
        val_nxt          = dec_r;
      end
      K_DAA: begin
        acc_nxt          = daa_r;
        flags_nxt        = szxy(daa_r);
        flags_nxt[FB_PV] = ~^daa_r;
        flags_nxt[FB_H]  = daa_h;
        flags_nxt[FB_N]  = nin;
        flags_nxt[FB_C]  = daa_c;
        val_nxt          = daa_r;
      end
      K_RLC, K_RRC, K_RL, K_RR, K_SLA, K_SRA, K_SLL, K_SRL: begin
        flags_nxt        = szxy(sh_r);
        flags_nxt[FB_PV] = ~^sh_r;
        flags_nxt[FB_C]  = sh_c;
        val_nxt          = sh_r;
      end
      K_BIT: begin
        flags_nxt        = '0;
        flags_nxt[FB_C]  = cin;
        flags_nxt[FB_H]  = 1'b1;
        flags_nxt[FB_5]  = s1_xy_r[5];
        flags_nxt[FB_3]  = s1_xy_r[3];
        flags_nxt[FB_Z]  = !bit_set;
        flags_nxt[FB_PV] = !bit_set;
        flags_nxt[FB_S]  = bit_set && (s1_bsel_r == 3'd7);
        val_nxt          = s1_b_r;
      end
      default: begin
        // unused codes pass everything through
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_acc_r   <= acc_nxt;
      out_flags_r <= flags_nxt;
      out_val_r   <= val_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.acc_out   = out_acc_r;
  assign out_ch.flags_out = out_flags_r;
  assign out_ch.value_out = out_val_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A held input item is never dropped.
  `EBALU_ASSERT(a_s1_hold, clk, rst_n, (s1_valid_r && !s2_load) |=> s1_valid_r)
  // Backpressure only when the input stage is occupied.
  `EBALU_ASSERT(a_ready_full, clk, rst_n, !in_ch.ready |-> s1_valid_r)
  // A stage move always produces a visible result.
  `EBALU_ASSERT(a_s2_valid, clk, rst_n, s2_load |=> out_valid_r)
  // Bit test always sets H and clears N.
  `EBALU_ASSERT(a_bit_flags, clk, rst_n,
    (s2_load && (s1_kind_r == K_BIT)) |=> (out_flags_r[FB_H] && !out_flags_r[FB_N]))
  // Both stages come out of reset empty.
  `EBALU_ASSERT(a_rst_empty, clk, rst_n, !$past(rst_n) |-> (!s1_valid_r && !out_valid_r))

endmodule

@@ tb/ebalu_result_check.sv @@
`timescale 1ns / 1ps

// Watches both channels, predicts each operation and compares results in order.
module ebalu_result_check
  import ebalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ebalu_in_if         in_mon,
  ebalu_out_if        out_mon,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned results_seen
);

  typedef struct packed {
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] flags;
    logic [BYTE_W-1:0] value;
  } alu_result_t;

  alu_result_t alu_results_q[$];

  // S, Z and the two copy bits, all from the byte r
  function automatic logic [BYTE_W-1:0] sign_zero_xy(logic [BYTE_W-1:0] r);
    logic [BYTE_W-1:0] f;
    f = '0;
    f[FB_S] = r[7];
    f[FB_Z] = (r == '0);
    f[FB_5] = r[5];
    f[FB_3] = r[3];
    return f;
  endfunction

  function automatic alu_result_t alu_outcome(
    logic [KIND_W-1:0] kind,
    logic [BYTE_W-1:0] a,
    logic [BYTE_W-1:0] fin,
    logic [BYTE_W-1:0] b,
    logic [BSEL_W-1:0] bsel,
    logic [BYTE_W-1:0] xy
  );
    alu_result_t       res;
    logic [BYTE_W:0]   wide;
    logic [4:0]        nib;
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] corr;
    logic              cin;
    logic              c;
    logic              value_is_acc;
    cin          = fin[FB_C];
    res.acc      = a;
    res.flags    = fin;
    res.value    = a;
    value_is_acc = 1'b1;
    case (kind)
      K_ADD, K_ADC: begin
        c    = (kind == K_ADC) ? cin : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, c};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
        r    = wide[7:0];
        res.flags        = sign_zero_xy(r);
        res.flags[FB_H]  = nib[4];
        res.flags[FB_C]  = wide[8];
        res.flags[FB_PV] = (a[7] == b[7]) && (r[7] != a[7]);
        res.acc          = r;
      end
      K_SUB, K_SBC, K_CP: begin
        c    = (kind == K_SBC) ? cin : 1'b0;
        wide = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, c};
        nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c};
        r    = wide[7:0];
        res.flags = sign_zero_xy(r);
        if (kind == K_CP) begin
          // compare copies bits 5 and 3 from the operand
          res.flags[FB_5] = b[5];
          res.flags[FB_3] = b[3];
        end
        res.flags[FB_N]  = 1'b1;
        res.flags[FB_H]  = nib[4];
        res.flags[FB_C]  = wide[8];
        res.flags[FB_PV] = (a[7] != b[7]) && (r[7] != a[7]);
        if (kind != K_CP) res.acc = r;
      end
      K_AND, K_OR, K_XOR: begin
        r = (kind == K_AND) ? (a & b) : (kind == K_OR) ? (a | b) : (a ^ b);
        res.flags        = sign_zero_xy(r);
        res.flags[FB_PV] = ~^r;
        res.flags[FB_H]  = (kind == K_AND);
        res.acc          = r;
      end
      K_INC: begin
        r = b + 8'h01;
        res.flags        = sign_zero_xy(r);
        res.flags[FB_C]  = cin;
        res.flags[FB_H]  = (b[3:0] == 4'hF);
        res.flags[FB_PV] = (b == 8'h7F);
        res.value        = r;
        value_is_acc     = 1'b0;
      end
      K_DEC: begin
        r = b - 8'h01;
        res.flags        = sign_zero_xy(r);
        res.flags[FB_N]  = 1'b1;
        res.flags[FB_C]  = cin;
        res.flags[FB_H]  = (b[3:0] == 4'h0);
        res.flags[FB_PV] = (b == 8'h80);
        res.value        = r;
        value_is_acc     = 1'b0;
      end
      K_DAA: begin
        corr = '0;
        c    = 1'b0;
        if (a[3:0] > 4'd9 || fin[FB_H]) corr = corr | 8'h06;
        if (a > 8'h99 || cin) begin
          corr = corr | 8'h60;
          c    = 1'b1;
        end
        r = fin[FB_N] ? (a - corr) : (a + corr);
        res.flags        = sign_zero_xy(r);
        res.flags[FB_PV] = ~^r;
        res.flags[FB_N]  = fin[FB_N];
        res.flags[FB_C]  = c;
        res.flags[FB_H]  = fin[FB_N] ? (fin[FB_H] && a[3:0] < 4'd6) : (a[3:0] > 4'd9);
        res.acc          = r;
      end
      K_RLC, K_RRC, K_RL, K_RR, K_SLA, K_SRA, K_SLL, K_SRL: begin
        case (kind)
          K_RLC:   begin c = b[7]; r = {b[6:0], b[7]}; end
          K_RRC:   begin c = b[0]; r = {b[0], b[7:1]}; end
          K_RL:    begin c = b[7]; r = {b[6:0], cin}; end
          K_RR:    begin c = b[0]; r = {cin, b[7:1]}; end
          K_SLA:   begin c = b[7]; r = {b[6:0], 1'b0}; end
          K_SRA:   begin c = b[0]; r = {b[7], b[7:1]}; end
          K_SLL:   begin c = b[7]; r = {b[6:0], 1'b1}; end
          default: begin c = b[0]; r = {1'b0, b[7:1]}; end
        endcase
        res.flags        = sign_zero_xy(r);
        res.flags[FB_PV] = ~^r;
        res.flags[FB_C]  = c;
        res.value        = r;
        value_is_acc     = 1'b0;
      end
      K_BIT: begin
        res.flags        = '0;
        res.flags[FB_C]  = cin;
        res.flags[FB_H]  = 1'b1;
        res.flags[FB_5]  = xy[5];
        res.flags[FB_3]  = xy[3];
        res.flags[FB_Z]  = !b[bsel];
        res.flags[FB_PV] = !b[bsel];
        res.flags[FB_S]  = b[bsel] && (bsel == 3'd7);
        res.value        = b;
        value_is_acc     = 1'b0;
      end
      default: ;  // unused codes pass through
    endcase
    if (value_is_acc) res.value = res.acc;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [BYTE_W-1:0] want,
                                 logic [BYTE_W-1:0] got);
    $display("%0t: mismatch on %s: expected %02h, got %02h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    alu_result_t got;
    alu_result_t want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.acc_out, out_mon.flags_out, out_mon.value_out};
        results_seen <= results_seen + 1;
        if (alu_results_q.size() == 0) begin
          report_mismatch("unrequested result, acc_out", 8'h00, got.acc);
        end else begin
          want = alu_results_q.pop_front();
          if (got.acc !== want.acc)     report_mismatch("acc_out", want.acc, got.acc);
          if (got.flags !== want.flags) report_mismatch("flags_out", want.flags, got.flags);
          if (got.value !== want.value) report_mismatch("value_out", want.value, got.value);
        end
      end
      if (in_mon.valid && in_mon.ready)
        alu_results_q.push_back(alu_outcome(in_mon.kind, in_mon.acc_in, in_mon.flags_in,
                                            in_mon.operand, in_mon.bit_select,
                                            in_mon.xy_byte));
      outstanding <= alu_results_q.size();
    end
  end

endmodule

@@ tb/eight_bit_alu_with_flags_test.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the flag ALU. Prediction and comparison live in
// ebalu_result_check, which sits beside the block and watches both channels.
module eight_bit_alu_with_flags_test;
  import ebalu_pkg::*;

  // codes outside the operation set; the block passes these through
  localparam logic [KIND_W-1:0] K_UNUSED_LO = 5'd20;
  localparam logic [KIND_W-1:0] K_UNUSED_HI = 5'd31;
  localparam int RANDOM_OPS = 900;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned ops_sent = 0;
  logic [31:0] codes_seen = '0;
  // pacing: 0 = never idle, 1 = light, 2 = heavy
  int          send_mode = 1;
  int          sink_mode = 1;

  ebalu_in_if  in_ch ();
  ebalu_out_if out_ch ();

  eight_bit_alu_with_flags dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ebalu_result_check result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always #10 clk = ~clk;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_cycles(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (roll < ((mode == 1) ? 70 : 30)) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Byte with a bias toward the carry, overflow and BCD boundaries.
  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return BYTE_W'($urandom);
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h0F;
      3:       return 8'h7F;
      4:       return 8'h80;
      5:       return 8'h99;
      6:       return 8'h9A;
      default: return 8'hFF;
    endcase
  endfunction

  // One transfer on in_ch, optionally preceded by an idle gap. Called at a
  // rising edge; returns right after the edge that took the item.
  task automatic issue(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] a, f, b,
                       logic [BSEL_W-1:0] bsel, logic [BYTE_W-1:0] xy);
    int gap;
    gap = idle_cycles(send_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.acc_in     <= a;
    in_ch.flags_in   <= f;
    in_ch.operand    <= b;
    in_ch.bit_select <= bsel;
    in_ch.xy_byte    <= xy;
    do @(posedge clk); while (!in_ch.ready);
    ops_sent++;
    codes_seen[kind] = 1'b1;
  endtask

  // Hold off the sender until every predicted result has come back. The
  // first edge lets the count pick up the transfer that just happened.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side: ready in bursts with random stalls, mode changes now and then.
  initial begin : sink_pacing
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) sink_mode = $urandom_range(0, 2);
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      stall = idle_cycles(sink_mode);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [KIND_W-1:0] kind;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= K_ADD;
    in_ch.acc_in     <= '0;
    in_ch.flags_in   <= '0;
    in_ch.operand    <= '0;
    in_ch.bit_select <= '0;
    in_ch.xy_byte    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and the corner of each operation but RRC, RL, SLA and SRL.
    issue(K_ADD, 8'hFF, 8'h00, 8'h01, 3'd0, 8'h00);  // wrap to zero, H and C
    issue(K_ADD, 8'h7F, 8'hFF, 8'h01, 3'd7, 8'hFF);  // signed overflow
    issue(K_ADC, 8'hFF, 8'h01, 8'hFF, 3'd0, 8'h00);  // carry in on top of max
    issue(K_SUB, 8'h80, 8'h00, 8'h01, 3'd0, 8'h00);  // signed overflow
    issue(K_SUB, 8'h00, 8'h00, 8'h01, 3'd0, 8'h00);  // borrow
    issue(K_SBC, 8'h10, 8'h01, 8'h0F, 3'd0, 8'h00);  // borrow in gives zero
    issue(K_AND, 8'hFF, 8'h00, 8'h00, 3'd0, 8'h00);
    issue(K_OR,  8'h55, 8'hFF, 8'hAA, 3'd0, 8'h00);
    issue(K_XOR, 8'hFF, 8'h00, 8'h7F, 3'd0, 8'h00);
    // compare: bits 5 and 3 from the operand, not the difference
    issue(K_CP,  8'h40, 8'h00, 8'h28, 3'd0, 8'h00);
    issue(K_CP,  8'hA5, 8'h01, 8'hA5, 3'd0, 8'h00);
    // inc/dec keep the incoming carry
    issue(K_INC, 8'h00, 8'h01, 8'h7F, 3'd0, 8'h00);
    issue(K_INC, 8'h33, 8'h00, 8'hFF, 3'd0, 8'h00);
    issue(K_DEC, 8'h00, 8'h01, 8'h80, 3'd0, 8'h00);
    issue(K_DEC, 8'hFF, 8'h00, 8'h00, 3'd0, 8'h00);
    // decimal adjust after add, after subtract with H, and with carry set
    issue(K_DAA, 8'h9A, 8'h00, 8'h00, 3'd0, 8'h00);
    issue(K_DAA, 8'h15, 8'h12, 8'h00, 3'd0, 8'h00);
    issue(K_DAA, 8'hF9, 8'h03, 8'h00, 3'd0, 8'h00);
    issue(K_RLC, 8'h00, 8'h00, 8'h81, 3'd0, 8'h00);
    issue(K_RR,  8'h00, 8'h01, 8'h01, 3'd0, 8'h00);
    issue(K_SRA, 8'h00, 8'h00, 8'h81, 3'd0, 8'h00);
    issue(K_SLL, 8'h00, 8'h00, 8'h80, 3'd0, 8'h00);
    // bit test: sign only for bit 7, copy bits from xy_byte
    issue(K_BIT, 8'h00, 8'h01, 8'h80, 3'd7, 8'h28);
    issue(K_BIT, 8'h00, 8'h00, 8'hFE, 3'd0, 8'hD7);
    issue(K_UNUSED_HI, 8'hC3, 8'h5A, 8'h11, 3'd5, 8'hFF);

    // Random body; every other operation and shift gets picked here as well.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 60 == 0) send_mode = $urandom_range(0, 2);
      if (i == 300 || i == 650) wait_drained();
      if ($urandom_range(0, 19) == 0)
        kind = KIND_W'($urandom_range(K_UNUSED_LO, K_UNUSED_HI));
      else
        kind = KIND_W'($urandom_range(K_ADD, K_BIT));
      issue(kind, pick_byte(), BYTE_W'($urandom), pick_byte(),
            BSEL_W'($urandom_range(0, 7)), BYTE_W'($urandom));
    end

    wait_drained();
    // two-stage pipeline: a few extra edges catch any stray result
    repeat (6) @(posedge clk);
    $display("Run covered %0d operations over %0d of the 32 operation codes,",
             ops_sent, $countones(codes_seen));
    $display("%0d results checked, with idle gaps and stalls on both channels",
             results_seen);
    $display("and two full drains mid-run.");
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("Timed out with %0d results still pending", outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ eight_bit_alu_with_flags.f @@
+incdir+rtl
rtl/ebalu_pkg.sv
rtl/ebalu_if.sv
rtl/eight_bit_alu_with_flags.sv
tb/ebalu_result_check.sv
tb/eight_bit_alu_with_flags_test.sv
